// ----- rtl/core/cth_pkg.sv -----
`default_nettype none

package cth_pkg;

  localparam int unsigned MAX_WIDTH  = 1024;
  localparam int unsigned MAX_HEIGHT = 1024;

  localparam int unsigned CHAN_W  = 8;
  localparam int unsigned COORD_W = 10;
  localparam int unsigned SIZE_W  = 11;
  localparam int unsigned COUNT_W = 21;
  localparam int unsigned SUM_W   = 30;
  localparam int unsigned PIX_W   = 3 * CHAN_W;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = COUNT_W;

  localparam logic [COUNT_W-1:0] COUNT_MAX = COUNT_W'(MAX_WIDTH * MAX_HEIGHT);
  localparam logic [SUM_W-1:0]   SUM_MAX   = {SUM_W{1'b1}};

  // Quotient bits produced by the divider; the mean of a coordinate fits the coordinate.
  localparam int unsigned DIV_STEPS = COORD_W;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

  // Channel 0 sits in the low byte.
  localparam logic [PIX_W-1:0] BOUND_LOW_RST  = {8'd100, 8'd0, 8'd60};
  localparam logic [PIX_W-1:0] BOUND_HIGH_RST = {8'd255, 8'd80, 8'd200};
  localparam logic [PIX_W-1:0] ROI_MIN_RST    = {PIX_W{1'b1}};
  localparam logic [PIX_W-1:0] ROI_MAX_RST    = {PIX_W{1'b0}};

  localparam logic [COORD_W-1:0] ROI_LEFT_RST   = COORD_W'(135);
  localparam logic [COORD_W-1:0] ROI_TOP_RST    = COORD_W'(95);
  localparam logic [SIZE_W-1:0]  ROI_WIDTH_RST  = SIZE_W'(50);
  localparam logic [SIZE_W-1:0]  ROI_HEIGHT_RST = SIZE_W'(50);
  localparam logic [COUNT_W-1:0] MIN_COUNT_RST  = COUNT_W'(3921);

  typedef enum logic [1:0] {
    MODE_NONE    = 2'd0,
    MODE_THRESH  = 2'd1,
    MODE_CAPTURE = 2'd2,
    MODE_UNUSED  = 2'd3
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE       = 3'd0,
    REG_ROI_LEFT   = 3'd1,
    REG_ROI_TOP    = 3'd2,
    REG_ROI_WIDTH  = 3'd3,
    REG_ROI_HEIGHT = 3'd4,
    REG_MIN_COUNT  = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic accept;
    logic div_start;
    logic div_step;
  } cmd_t;

  typedef struct packed {
    logic need_div;
  } status_t;

endpackage

`default_nettype wire

// ----- rtl/core/cth_div.sv -----
`default_nettype none

// Two restoring dividers side by side, one quotient bit per step.
// The sum of a coordinate never exceeds count * 1023, so the quotient
// fits COORD_W bits and the upper dividend bits start out below the divisor.
module cth_div (
  input  wire logic                        clk,
  input  wire logic                        start,
  input  wire logic                        step,
  input  wire logic [cth_pkg::SUM_W-1:0]   sum_x,
  input  wire logic [cth_pkg::SUM_W-1:0]   sum_y,
  input  wire logic [cth_pkg::COUNT_W-1:0] count,
  output logic      [cth_pkg::COORD_W-1:0] quot_x,
  output logic      [cth_pkg::COORD_W-1:0] quot_y
);

  localparam int unsigned RW = cth_pkg::COUNT_W;
  localparam int unsigned LW = cth_pkg::DIV_STEPS;

  logic [RW-1:0] divisor;
  logic [RW-1:0] rem_x, rem_y;
  logic [LW-1:0] low_x, low_y;
  logic [RW:0]   trial_x, trial_y;
  logic [RW:0]   diff_x, diff_y;
  logic          take_x, take_y;

  always_comb begin
    trial_x = {rem_x, low_x[LW-1]};
    trial_y = {rem_y, low_y[LW-1]};
    diff_x  = trial_x - {1'b0, divisor};
    diff_y  = trial_y - {1'b0, divisor};
    take_x  = trial_x >= {1'b0, divisor};
    take_y  = trial_y >= {1'b0, divisor};
  end

  always_ff @(posedge clk) begin
    if (start) begin
      divisor <= count;
      rem_x   <= RW'(sum_x[cth_pkg::SUM_W-1:LW]);
      rem_y   <= RW'(sum_y[cth_pkg::SUM_W-1:LW]);
      low_x   <= sum_x[LW-1:0];
      low_y   <= sum_y[LW-1:0];
      quot_x  <= '0;
      quot_y  <= '0;
    end else if (step) begin
      rem_x  <= take_x ? diff_x[RW-1:0] : trial_x[RW-1:0];
      rem_y  <= take_y ? diff_y[RW-1:0] : trial_y[RW-1:0];
      low_x  <= {low_x[LW-2:0], 1'b0};
      low_y  <= {low_y[LW-2:0], 1'b0};
      quot_x <= {quot_x[LW-2:0], take_x};
      quot_y <= {quot_y[LW-2:0], take_y};
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/cth_datapath.sv -----
`default_nettype none

module cth_datapath (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire cth_pkg::cmd_t                  cmd,
  output cth_pkg::status_t                    status,
  input  wire logic                           cfg_write,
  input  wire logic [cth_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [cth_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic [cth_pkg::CHAN_W-1:0]     chan0,
  input  wire logic [cth_pkg::CHAN_W-1:0]     chan1,
  input  wire logic [cth_pkg::CHAN_W-1:0]     chan2,
  input  wire logic [cth_pkg::COORD_W-1:0]    pix_x,
  input  wire logic [cth_pkg::COORD_W-1:0]    pix_y,
  input  wire logic                           frame_end,
  output logic                                mask,
  output logic                                frame_done,
  output logic                                found,
  output logic      [cth_pkg::COORD_W-1:0]    centroid_x,
  output logic      [cth_pkg::COORD_W-1:0]    centroid_y,
  output logic      [cth_pkg::COUNT_W-1:0]    pixel_count
);

  localparam int unsigned CW = cth_pkg::CHAN_W;

  // configuration
  logic [1:0]                    mode;
  logic [cth_pkg::COORD_W-1:0]   roi_left, roi_top;
  logic [cth_pkg::SIZE_W-1:0]    roi_width, roi_height;
  logic [cth_pkg::COUNT_W-1:0]   min_count;

  // frame state
  logic [cth_pkg::PIX_W-1:0]     bound_low, bound_high;
  logic [cth_pkg::PIX_W-1:0]     roi_min, roi_max;
  logic                          roi_seen;
  logic [cth_pkg::COUNT_W-1:0]   marked_count;
  logic [cth_pkg::SUM_W-1:0]     sum_col, sum_row;

  logic [cth_pkg::PIX_W-1:0]     pix;
  logic                          is_thresh, is_capture;
  logic                          inside_bounds, in_roi;
  logic                          count_en;
  logic [cth_pkg::SIZE_W:0]      roi_right, roi_bottom;
  logic [cth_pkg::SUM_W:0]       col_add, row_add;
  logic [cth_pkg::COUNT_W-1:0]   marked_count_next;
  logic [cth_pkg::SUM_W-1:0]     sum_col_next, sum_row_next;
  logic [cth_pkg::PIX_W-1:0]     roi_min_next, roi_max_next;
  logic                          roi_seen_next;
  logic                          found_next;
  logic [cth_pkg::COORD_W-1:0]   quot_x, quot_y;

  assign pix        = {chan2, chan1, chan0};
  assign is_thresh  = mode == cth_pkg::MODE_THRESH;
  assign is_capture = mode == cth_pkg::MODE_CAPTURE;

  always_comb begin
    inside_bounds = 1'b1;
    for (int c = 0; c < 3; c++) begin
      if (pix[c*CW +: CW] < bound_low[c*CW +: CW] ||
          pix[c*CW +: CW] > bound_high[c*CW +: CW]) begin
        inside_bounds = 1'b0;
      end
    end
  end

  always_comb begin
    roi_right  = {2'b0, roi_left}  + {1'b0, roi_width};
    roi_bottom = {2'b0, roi_top}   + {1'b0, roi_height};
    in_roi = pix_x >= roi_left && {2'b0, pix_x} < roi_right &&
             pix_y >= roi_top  && {2'b0, pix_y} < roi_bottom;
  end

  always_comb begin
    count_en = is_thresh && inside_bounds && marked_count < cth_pkg::COUNT_MAX;
    col_add  = {1'b0, sum_col} + (cth_pkg::SUM_W + 1)'(pix_x);
    row_add  = {1'b0, sum_row} + (cth_pkg::SUM_W + 1)'(pix_y);
    marked_count_next = marked_count;
    sum_col_next      = sum_col;
    sum_row_next      = sum_row;
    if (count_en) begin
      marked_count_next = marked_count + 1'b1;
      sum_col_next = (col_add > {1'b0, cth_pkg::SUM_MAX}) ? cth_pkg::SUM_MAX
                                                         : col_add[cth_pkg::SUM_W-1:0];
      sum_row_next = (row_add > {1'b0, cth_pkg::SUM_MAX}) ? cth_pkg::SUM_MAX
                                                         : row_add[cth_pkg::SUM_W-1:0];
    end
  end

  always_comb begin
    roi_min_next  = roi_min;
    roi_max_next  = roi_max;
    roi_seen_next = roi_seen;
    if (is_capture && in_roi) begin
      for (int c = 0; c < 3; c++) begin
        if (pix[c*CW +: CW] < roi_min[c*CW +: CW]) roi_min_next[c*CW +: CW] = pix[c*CW +: CW];
        if (pix[c*CW +: CW] > roi_max[c*CW +: CW]) roi_max_next[c*CW +: CW] = pix[c*CW +: CW];
      end
      roi_seen_next = 1'b1;
    end
  end

  assign found_next = frame_end && is_thresh &&
                      marked_count_next > min_count && marked_count_next != '0;
  assign status.need_div = found_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= cth_pkg::MODE_NONE;
      roi_left   <= cth_pkg::ROI_LEFT_RST;
      roi_top    <= cth_pkg::ROI_TOP_RST;
      roi_width  <= cth_pkg::ROI_WIDTH_RST;
      roi_height <= cth_pkg::ROI_HEIGHT_RST;
      min_count  <= cth_pkg::MIN_COUNT_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        cth_pkg::REG_MODE:       mode       <= cfg_data[1:0];
        cth_pkg::REG_ROI_LEFT:   roi_left   <= cfg_data[cth_pkg::COORD_W-1:0];
        cth_pkg::REG_ROI_TOP:    roi_top    <= cfg_data[cth_pkg::COORD_W-1:0];
        cth_pkg::REG_ROI_WIDTH:  roi_width  <= cfg_data[cth_pkg::SIZE_W-1:0];
        cth_pkg::REG_ROI_HEIGHT: roi_height <= cfg_data[cth_pkg::SIZE_W-1:0];
        cth_pkg::REG_MIN_COUNT:  min_count  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bound_low    <= cth_pkg::BOUND_LOW_RST;
      bound_high   <= cth_pkg::BOUND_HIGH_RST;
      roi_min      <= cth_pkg::ROI_MIN_RST;
      roi_max      <= cth_pkg::ROI_MAX_RST;
      roi_seen     <= 1'b0;
      marked_count <= '0;
      sum_col      <= '0;
      sum_row      <= '0;
    end else if (cmd.accept) begin
      if (frame_end) begin
        if (is_capture && roi_seen_next) begin
          bound_low  <= roi_min_next;
          bound_high <= roi_max_next;
        end
        // clear after the last pixel has been taken in
        roi_min      <= cth_pkg::ROI_MIN_RST;
        roi_max      <= cth_pkg::ROI_MAX_RST;
        roi_seen     <= 1'b0;
        marked_count <= '0;
        sum_col      <= '0;
        sum_row      <= '0;
      end else begin
        roi_min      <= roi_min_next;
        roi_max      <= roi_max_next;
        roi_seen     <= roi_seen_next;
        marked_count <= marked_count_next;
        sum_col      <= sum_col_next;
        sum_row      <= sum_row_next;
      end
    end
  end

  // result payload; centroid comes from the divider once it finishes
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      mask        <= is_thresh && inside_bounds;
      frame_done  <= frame_end;
      found       <= found_next;
      pixel_count <= (frame_end && is_thresh) ? marked_count_next : '0;
    end
  end

  cth_div u_div (
    .clk    (clk),
    .start  (cmd.div_start),
    .step   (cmd.div_step),
    .sum_x  (sum_col_next),
    .sum_y  (sum_row_next),
    .count  (marked_count_next),
    .quot_x (quot_x),
    .quot_y (quot_y)
  );

  assign centroid_x = found ? quot_x : '0;
  assign centroid_y = found ? quot_y : '0;

endmodule

`default_nettype wire

// ----- rtl/core/cth_ctrl.sv -----
`default_nettype none

module cth_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  wire logic             out_ready,
  input  wire cth_pkg::status_t status,
  output cth_pkg::cmd_t         cmd
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_DIV  = 2'b10
  } state_t;

  state_t                          state, state_next;
  logic [cth_pkg::DIV_CNT_W-1:0]   step_cnt, step_cnt_next;
  logic                            out_valid_next;
  logic                            last_step;

  assign last_step = step_cnt == cth_pkg::DIV_CNT_W'(cth_pkg::DIV_STEPS - 1);

  // in idle, an empty or draining output register lets the next pixel in
  assign in_ready = state == ST_IDLE && (!out_valid || out_ready);

  always_comb begin
    cmd.accept    = in_valid && in_ready;
    cmd.div_start = 1'b0;
    cmd.div_step  = 1'b0;
    state_next    = state;
    step_cnt_next = step_cnt;
    out_valid_next = out_valid && !out_ready;
    unique case (state)
      ST_IDLE: begin
        if (cmd.accept) begin
          if (status.need_div) begin
            cmd.div_start = 1'b1;
            step_cnt_next = '0;
            state_next    = ST_DIV;
          end else begin
            out_valid_next = 1'b1;
          end
        end
      end
      ST_DIV: begin
        cmd.div_step  = 1'b1;
        step_cnt_next = step_cnt + 1'b1;
        if (last_step) begin
          out_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      step_cnt  <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      step_cnt  <= step_cnt_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/color_threshold_centroid.sv -----
`default_nettype none

// Channel  Handshake                 Payload
// in       in_valid / in_ready       chan0 chan1 chan2 pix_x pix_y frame_end
// out      out_valid / out_ready     mask frame_done found centroid_x centroid_y pixel_count
// cfg      cfg_valid / cfg_ready     cfg_index cfg_data
//
// One pixel per cycle while the divider is idle and no result is held; each result sits in an output register.
// A frame end in threshold mode with an object found runs the divider (one centroid bit per
// cycle) before its result is valid, and no new pixel is taken in meanwhile.
// Synchronous reset loads the register defaults and clears the frame accumulators.
// A held result stalls input only when out_ready stays low.
module color_threshold_centroid (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [cth_pkg::CHAN_W-1:0]     chan0,
  input  wire logic [cth_pkg::CHAN_W-1:0]     chan1,
  input  wire logic [cth_pkg::CHAN_W-1:0]     chan2,
  input  wire logic [cth_pkg::COORD_W-1:0]    pix_x,
  input  wire logic [cth_pkg::COORD_W-1:0]    pix_y,
  input  wire logic                           frame_end,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic                                mask,
  output logic                                frame_done,
  output logic                                found,
  output logic      [cth_pkg::COORD_W-1:0]    centroid_x,
  output logic      [cth_pkg::COORD_W-1:0]    centroid_y,
  output logic      [cth_pkg::COUNT_W-1:0]    pixel_count,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [cth_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [cth_pkg::CFG_DATA_W-1:0] cfg_data
);

  cth_pkg::cmd_t    cmd;
  cth_pkg::status_t status;

  assign cfg_ready = 1'b1;

  cth_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  cth_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .cfg_write   (cfg_valid && cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .chan0       (chan0),
    .chan1       (chan1),
    .chan2       (chan2),
    .pix_x       (pix_x),
    .pix_y       (pix_y),
    .frame_end   (frame_end),
    .mask        (mask),
    .frame_done  (frame_done),
    .found       (found),
    .centroid_x  (centroid_x),
    .centroid_y  (centroid_y),
    .pixel_count (pixel_count)
  );

endmodule

`default_nettype wire
